// ===== rtl/feather_blend_accumulate_normalize_top_macros.svh =====
// Assertion macros for the feathered blending canvas.
// Included by the top level; needs a clock named aclk and a reset named aresetn.
`ifndef FEATHER_BLEND_ACCUMULATE_NORMALIZE_TOP_MACROS_SVH
`define FEATHER_BLEND_ACCUMULATE_NORMALIZE_TOP_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define FBAN_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define FBAN_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fban_pkg.sv =====
// Shared constants, types and arithmetic helpers of the feathered blending canvas.
// No dependencies; used by the top level.
package fban_pkg;

    // Canvas geometry.
    localparam int CANVAS_WIDTH  = 256;
    localparam int CANVAS_HEIGHT = 256;
    localparam int CANVAS_CELLS  = CANVAS_WIDTH * CANVAS_HEIGHT;
    localparam int CANVAS_AW     = $clog2(CANVAS_CELLS);
    localparam int COORD_W       = 8;
    localparam int PIXEL_W       = 8;

    // Weight format: Q1.16.
    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int WEIGHT_W         = WEIGHT_FRAC_BITS + 1;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};
    localparam int PROD_W           = PIXEL_W + WEIGHT_W;

    // Canvas sums.
    localparam int COLOR_SUM_W = 29;
    localparam int WSUM_W      = 21;

    // Normalising divider: one quotient bit per stage.
    localparam int QUOT_BITS  = PIXEL_W;
    localparam int DIV_STAGES = QUOT_BITS;
    localparam int SHIFT_W    = $clog2(QUOT_BITS);

    // Result queue.
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    // Configuration registers.
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 17;
    localparam int SPAN_START_W = 8;
    localparam int SPAN_END_W   = 9;
    localparam int FEATHER_W    = 8;
    localparam int RAMP_STEP_W  = 17;
    localparam logic [SPAN_END_W-1:0] SPAN_END_RESET = 9'd256;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SPAN_START    = 2'd0,
        CFG_SPAN_END      = 2'd1,
        CFG_FEATHER_WIDTH = 2'd2,
        CFG_RAMP_STEP     = 2'd3
    } cfg_index_t;

    // Commands.
    localparam logic CMD_ACCUMULATE = 1'b0;
    localparam logic CMD_READ       = 1'b1;

    // One canvas cell as it is held in memory.
    typedef struct packed {
        logic [COLOR_SUM_W-1:0] red;
        logic [COLOR_SUM_W-1:0] green;
        logic [COLOR_SUM_W-1:0] blue;
        logic [WSUM_W-1:0]      weight;
    } canvas_entry_t;

    // One normalised result word.
    typedef struct packed {
        logic [PIXEL_W-1:0] red;
        logic [PIXEL_W-1:0] green;
        logic [PIXEL_W-1:0] blue;
        logic               covered;
    } result_t;

    // Outcome of one restoring division step.
    typedef struct packed {
        logic [COLOR_SUM_W-1:0] rem;
        logic                   qbit;
    } div_step_t;

    // Colour sum plus weighted pixel, saturating at the sum's maximum.
    function automatic logic [COLOR_SUM_W-1:0] sat_add_color(
        input logic [COLOR_SUM_W-1:0] acc,
        input logic [PROD_W-1:0]      add
    );
        logic [COLOR_SUM_W:0] s;
        s = {1'b0, acc} + (COLOR_SUM_W + 1)'(add);
        return s[COLOR_SUM_W] ? {COLOR_SUM_W{1'b1}} : s[COLOR_SUM_W-1:0];
    endfunction

    // Weight sum plus weight, saturating at the sum's maximum.
    function automatic logic [WSUM_W-1:0] sat_add_weight(
        input logic [WSUM_W-1:0]   acc,
        input logic [WEIGHT_W-1:0] add
    );
        logic [WSUM_W:0] s;
        s = {1'b0, acc} + (WSUM_W + 1)'(add);
        return s[WSUM_W] ? {WSUM_W{1'b1}} : s[WSUM_W-1:0];
    endfunction

    // True when the quotient would not fit in QUOT_BITS bits.
    function automatic logic div_saturates(
        input logic [COLOR_SUM_W-1:0] whole,
        input logic [WSUM_W-1:0]      wsum
    );
        logic [COLOR_SUM_W:0] lim;
        lim = (COLOR_SUM_W + 1)'(wsum) << QUOT_BITS;
        return {1'b0, whole} >= lim;
    endfunction

    // One restoring division step against the divisor shifted by sh.
    function automatic div_step_t div_step(
        input logic [COLOR_SUM_W-1:0] rem,
        input logic [WSUM_W-1:0]      wsum,
        input logic [SHIFT_W-1:0]     sh
    );
        logic [COLOR_SUM_W:0] shifted;
        logic [COLOR_SUM_W:0] diff;
        div_step_t            res;
        shifted  = (COLOR_SUM_W + 1)'(wsum) << sh;
        diff     = {1'b0, rem} - shifted;
        res.qbit = !diff[COLOR_SUM_W];
        res.rem  = res.qbit ? diff[COLOR_SUM_W-1:0] : rem;
        return res;
    endfunction

endpackage

// ===== rtl/fban_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies; holds the canvas of the blending block.
module fban_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port; a read of the address being written returns the old word.
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/feather_blend_accumulate_normalize_top.sv =====
// Feathered blending canvas with accumulate and normalised read-out.
// Depends on fban_pkg, fban_ram and the assertion macro header.
//
// Usage:
//   The s_ channel carries one command word per handshake. An accumulate word
//   weights its RGB pixel by the column feather weight and adds it into the
//   canvas cell at (row, column); it gives no result. A read word returns one
//   result word on the m_ channel: the cell's colour sums divided by its weight
//   sum, saturated at 255, or all zero when the cell is uncovered.
//   The cfg channel writes the span, feather width and ramp step registers; it
//   is always ready. It is to be written only while the block is idle; the block itself does not enforce this.
// Timing:
//   One word is accepted per cycle while s_ready is high. A read result passes
//   through weighting and the canvas read-modify-write, then the divider stages
//   that give the quotient bits, and then enters the result queue. Back-to-back
//   updates of one canvas cell are forwarded.
// Reset and stalls:
//   After reset the canvas is cleared one cell per cycle, all 65536 cells, with
//   s_ready low. Results wait in a 16-word queue; s_ready falls only when the
//   queue and the reads in flight would fill it.
`include "feather_blend_accumulate_normalize_top_macros.svh"

module feather_blend_accumulate_normalize_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fban_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fban_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Command channel.
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_command,
    input  logic [fban_pkg::COORD_W-1:0]        s_row,
    input  logic [fban_pkg::COORD_W-1:0]        s_column,
    input  logic [fban_pkg::PIXEL_W-1:0]        s_pixel_red,
    input  logic [fban_pkg::PIXEL_W-1:0]        s_pixel_green,
    input  logic [fban_pkg::PIXEL_W-1:0]        s_pixel_blue,
    // Result channel.
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [fban_pkg::PIXEL_W-1:0]        m_out_red,
    output logic [fban_pkg::PIXEL_W-1:0]        m_out_green,
    output logic [fban_pkg::PIXEL_W-1:0]        m_out_blue,
    output logic                                m_covered
);

    localparam int AW  = fban_pkg::CANVAS_AW;
    localparam int PW  = fban_pkg::PIXEL_W;
    localparam int WW  = fban_pkg::WEIGHT_W;
    localparam int XW  = fban_pkg::PROD_W;
    localparam int CW  = fban_pkg::COLOR_SUM_W;
    localparam int SW  = fban_pkg::WSUM_W;
    localparam int QW  = fban_pkg::QUOT_BITS;
    localparam int DS  = fban_pkg::DIV_STAGES;
    localparam int FD  = fban_pkg::FIFO_DEPTH;
    localparam int FAW = fban_pkg::FIFO_AW;
    localparam int FCW = fban_pkg::FIFO_CW;

    // Configuration registers.
    logic [fban_pkg::SPAN_START_W-1:0] span_start_reg;
    logic [fban_pkg::SPAN_END_W-1:0]   span_end_reg;
    logic [fban_pkg::FEATHER_W-1:0]    feather_width_reg;
    logic [fban_pkg::RAMP_STEP_W-1:0]  ramp_step_reg;

    // Clearing pass.
    logic          clr_active_reg;
    logic [AW-1:0] clr_addr_reg;

    // Handshakes and credits.
    logic           s_accept;
    logic           read_accept;
    logic           m_accept;
    logic [FCW-1:0] resv_reg;
    logic [FCW-1:0] resv_next;

    // Column weighting at the input.
    logic                              in_span;
    logic [fban_pkg::SPAN_END_W-1:0]   span_len;
    logic                              span_narrow;
    logic [PW-1:0]                     span_half;
    logic [PW-1:0]                     blend_width;
    logic                              ramp_on;
    logic [PW-1:0]                     ramp_k;
    logic [fban_pkg::SPAN_END_W-1:0]   ramp_r;
    logic                              in_ramp;
    logic [PW-1:0]                     ramp_pos;

    // Stage 1: ramp position.
    logic          s1_v_reg;
    logic          s1_cmd_reg;
    logic [AW-1:0] s1_addr_reg;
    logic [PW-1:0] s1_red_reg;
    logic [PW-1:0] s1_green_reg;
    logic [PW-1:0] s1_blue_reg;
    logic          s1_ramp_reg;
    logic [PW-1:0] s1_pos_reg;
    logic [XW-1:0] s1_ramp_prod;
    logic [WW-1:0] s1_weight;

    // Stage 2: weight known; canvas read issued.
    logic          s2_v_reg;
    logic          s2_cmd_reg;
    logic [AW-1:0] s2_addr_reg;
    logic [PW-1:0] s2_red_reg;
    logic [PW-1:0] s2_green_reg;
    logic [PW-1:0] s2_blue_reg;
    logic [WW-1:0] s2_weight_reg;
    logic [XW-1:0] s2_wred;
    logic [XW-1:0] s2_wgreen;
    logic [XW-1:0] s2_wblue;

    // Stage 3: read-modify-write of the canvas cell.
    logic          s3_v_reg;
    logic          s3_cmd_reg;
    logic [AW-1:0] s3_addr_reg;
    logic [WW-1:0] s3_weight_reg;
    logic [XW-1:0] s3_wred_reg;
    logic [XW-1:0] s3_wgreen_reg;
    logic [XW-1:0] s3_wblue_reg;
    logic          s3_nonzero_reg;
    fban_pkg::canvas_entry_t ram_rd_entry;
    fban_pkg::canvas_entry_t s3_cell;
    fban_pkg::canvas_entry_t s3_update;
    logic                    s3_write;

    // Last canvas write, for forwarding.
    logic                    wb_v_reg;
    logic [AW-1:0]           wb_addr_reg;
    fban_pkg::canvas_entry_t wb_data_reg;

    // Canvas memory ports.
    logic                    ram_wr_en;
    logic [AW-1:0]           ram_wr_addr;
    fban_pkg::canvas_entry_t ram_wr_data;

    // Divider pipeline, one quotient bit per stage.
    logic              div_v_reg     [0:DS];
    logic [SW-1:0]     div_wsum_reg  [0:DS];
    logic              div_cov_reg   [0:DS];
    logic [CW-1:0]     div_rem_reg   [0:DS][0:2];
    logic [QW-1:0]     div_q_reg     [0:DS][0:2];
    logic              div_sat_reg   [0:DS][0:2];
    fban_pkg::div_step_t div_res     [0:DS-1][0:2];
    logic              div_sat_first [0:2];
    logic [CW-1:0]     s3_whole      [0:2];
    logic [PW-1:0]     div_out       [0:2];
    fban_pkg::result_t div_result;

    // Result queue.
    fban_pkg::result_t fifo_reg [0:FD-1];
    logic [FAW-1:0]    fifo_wr_ptr_reg;
    logic [FAW-1:0]    fifo_rd_ptr_reg;
    logic [FCW-1:0]    fifo_cnt_reg;
    logic [FCW-1:0]    fifo_cnt_next;
    logic              fifo_push;
    fban_pkg::result_t fifo_head;

    // Configuration writes.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            span_start_reg    <= '0;
            span_end_reg      <= fban_pkg::SPAN_END_RESET;
            feather_width_reg <= '0;
            ramp_step_reg     <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (fban_pkg::cfg_index_t'(cfg_index))
                fban_pkg::CFG_SPAN_START: begin
                    span_start_reg <= cfg_data[fban_pkg::SPAN_START_W-1:0];
                end
                fban_pkg::CFG_SPAN_END: begin
                    span_end_reg <= cfg_data[fban_pkg::SPAN_END_W-1:0];
                end
                fban_pkg::CFG_FEATHER_WIDTH: begin
                    feather_width_reg <= cfg_data[fban_pkg::FEATHER_W-1:0];
                end
                fban_pkg::CFG_RAMP_STEP: begin
                    ramp_step_reg <= cfg_data[fban_pkg::RAMP_STEP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Clearing pass over the whole canvas after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == {AW{1'b1}}) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // Input handshake; credits reserve a queue slot for every read in flight.
    assign s_ready     = !clr_active_reg && (resv_reg < FCW'(FD));
    assign s_accept    = s_valid && s_ready;
    assign read_accept = s_accept && (s_command == fban_pkg::CMD_READ);
    assign m_accept    = m_valid && m_ready;

    always_comb begin
        resv_next = resv_reg;
        if (read_accept && !m_accept) begin
            resv_next = resv_reg + 1'b1;
        end else if (!read_accept && m_accept) begin
            resv_next = resv_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            resv_reg <= '0;
        end else begin
            resv_reg <= resv_next;
        end
    end

    // Span test and ramp position of the incoming column.
    always_comb begin
        in_span     = (s_column >= span_start_reg) && ({1'b0, s_column} < span_end_reg);
        span_len    = span_end_reg - {1'b0, span_start_reg};
        span_narrow = {1'b0, span_len} < {1'b0, feather_width_reg, 1'b0};
        span_half   = span_len[fban_pkg::SPAN_END_W-1:1];
        blend_width = span_narrow ? (span_half - 1'b1) : feather_width_reg;
        ramp_on     = span_narrow ? (span_half > PW'(1)) : (feather_width_reg != '0);
        ramp_k      = s_column - span_start_reg;
        ramp_r      = span_end_reg - 1'b1 - {1'b0, s_column};
        in_ramp     = 1'b0;
        ramp_pos    = ramp_k;
        if (ramp_k < blend_width) begin
            in_ramp  = ramp_on;
        end else if (ramp_r < {1'b0, blend_width}) begin
            in_ramp  = ramp_on;
            ramp_pos = ramp_r[PW-1:0];
        end
    end

    // Stage valids; accumulates outside the span are dropped at the input.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end else begin
            s1_v_reg <= s_accept && ((s_command == fban_pkg::CMD_READ) || in_span);
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    // Stage 1 payload.
    always_ff @(posedge aclk) begin
        s1_cmd_reg   <= s_command;
        s1_addr_reg  <= {s_row, s_column};
        s1_red_reg   <= s_pixel_red;
        s1_green_reg <= s_pixel_green;
        s1_blue_reg  <= s_pixel_blue;
        s1_ramp_reg  <= in_ramp;
        s1_pos_reg   <= ramp_pos;
    end

    // Ramp weight, saturated at one.
    always_comb begin
        s1_ramp_prod = XW'(s1_pos_reg) * XW'(ramp_step_reg);
        s1_weight    = fban_pkg::WEIGHT_ONE;
        if (s1_ramp_reg && (s1_ramp_prod < XW'(fban_pkg::WEIGHT_ONE))) begin
            s1_weight = s1_ramp_prod[WW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        s2_cmd_reg    <= s1_cmd_reg;
        s2_addr_reg   <= s1_addr_reg;
        s2_red_reg    <= s1_red_reg;
        s2_green_reg  <= s1_green_reg;
        s2_blue_reg   <= s1_blue_reg;
        s2_weight_reg <= s1_weight;
    end

    // Weighted colours.
    assign s2_wred   = XW'(s2_red_reg) * XW'(s2_weight_reg);
    assign s2_wgreen = XW'(s2_green_reg) * XW'(s2_weight_reg);
    assign s2_wblue  = XW'(s2_blue_reg) * XW'(s2_weight_reg);

    always_ff @(posedge aclk) begin
        s3_cmd_reg     <= s2_cmd_reg;
        s3_addr_reg    <= s2_addr_reg;
        s3_weight_reg  <= s2_weight_reg;
        s3_wred_reg    <= s2_wred;
        s3_wgreen_reg  <= s2_wgreen;
        s3_wblue_reg   <= s2_wblue;
        s3_nonzero_reg <= (s2_wred != '0) || (s2_wgreen != '0) || (s2_wblue != '0);
    end

    // Canvas cell with forwarding of the write made in the cycle of the read.
    always_comb begin
        s3_cell = ram_rd_entry;
        if (wb_v_reg && (wb_addr_reg == s3_addr_reg)) begin
            s3_cell = wb_data_reg;
        end
        s3_update.red    = fban_pkg::sat_add_color(s3_cell.red, s3_wred_reg);
        s3_update.green  = fban_pkg::sat_add_color(s3_cell.green, s3_wgreen_reg);
        s3_update.blue   = fban_pkg::sat_add_color(s3_cell.blue, s3_wblue_reg);
        s3_update.weight = s3_nonzero_reg
                         ? fban_pkg::sat_add_weight(s3_cell.weight, s3_weight_reg)
                         : s3_cell.weight;
        s3_write = s3_v_reg && (s3_cmd_reg == fban_pkg::CMD_ACCUMULATE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wb_v_reg <= 1'b0;
        end else if (s3_write) begin
            wb_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_write) begin
            wb_addr_reg <= s3_addr_reg;
            wb_data_reg <= s3_update;
        end
    end

    // Canvas memory; the clearing pass owns the write port after reset.
    assign ram_wr_en   = clr_active_reg || s3_write;
    assign ram_wr_addr = clr_active_reg ? clr_addr_reg : s3_addr_reg;
    assign ram_wr_data = clr_active_reg ? '0 : s3_update;

    fban_ram #(
        .WIDTH ($bits(fban_pkg::canvas_entry_t)),
        .DEPTH (fban_pkg::CANVAS_CELLS)
    ) u_canvas_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (s2_addr_reg),
        .rd_data (ram_rd_entry)
    );

    // Integer parts of the colour sums, kept at their fixed-point position.
    always_comb begin
        s3_whole[0] = {s3_cell.red[CW-1:fban_pkg::WEIGHT_FRAC_BITS],
                       {fban_pkg::WEIGHT_FRAC_BITS{1'b0}}};
        s3_whole[1] = {s3_cell.green[CW-1:fban_pkg::WEIGHT_FRAC_BITS],
                       {fban_pkg::WEIGHT_FRAC_BITS{1'b0}}};
        s3_whole[2] = {s3_cell.blue[CW-1:fban_pkg::WEIGHT_FRAC_BITS],
                       {fban_pkg::WEIGHT_FRAC_BITS{1'b0}}};
    end

    // Division steps and the overflow test of the first stage.
    always_comb begin
        for (int j = 0; j < DS; j++) begin
            for (int c = 0; c < 3; c++) begin
                div_res[j][c] = fban_pkg::div_step(div_rem_reg[j][c], div_wsum_reg[j],
                                                   fban_pkg::SHIFT_W'(QW - 1 - j));
            end
        end
        for (int c = 0; c < 3; c++) begin
            div_sat_first[c] = fban_pkg::div_saturates(div_rem_reg[0][c], div_wsum_reg[0]);
        end
    end

    // Divider valids.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j <= DS; j++) begin
                div_v_reg[j] <= 1'b0;
            end
        end else begin
            div_v_reg[0] <= s3_v_reg && (s3_cmd_reg == fban_pkg::CMD_READ);
            for (int j = 0; j < DS; j++) begin
                div_v_reg[j+1] <= div_v_reg[j];
            end
        end
    end

    // Divider payload.
    always_ff @(posedge aclk) begin
        div_wsum_reg[0] <= s3_cell.weight;
        div_cov_reg[0]  <= (s3_cell.weight != '0);
        for (int c = 0; c < 3; c++) begin
            div_rem_reg[0][c] <= s3_whole[c];
            div_q_reg[0][c]   <= '0;
            div_sat_reg[0][c] <= 1'b0;
        end
        for (int j = 0; j < DS; j++) begin
            div_wsum_reg[j+1] <= div_wsum_reg[j];
            div_cov_reg[j+1]  <= div_cov_reg[j];
            for (int c = 0; c < 3; c++) begin
                div_rem_reg[j+1][c] <= div_res[j][c].rem;
                div_q_reg[j+1][c]   <= {div_q_reg[j][c][QW-2:0], div_res[j][c].qbit};
                div_sat_reg[j+1][c] <= (j == 0) ? div_sat_first[c] : div_sat_reg[j][c];
            end
        end
    end

    // Final result: saturated quotient, or zero for an uncovered cell.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            div_out[c] = '0;
            if (div_cov_reg[DS]) begin
                div_out[c] = div_sat_reg[DS][c] ? {PW{1'b1}} : div_q_reg[DS][c];
            end
        end
        div_result.red     = div_out[0];
        div_result.green   = div_out[1];
        div_result.blue    = div_out[2];
        div_result.covered = div_cov_reg[DS];
    end

    // Result queue.
    assign fifo_push = div_v_reg[DS];

    always_comb begin
        fifo_cnt_next = fifo_cnt_reg;
        if (fifo_push && !m_accept) begin
            fifo_cnt_next = fifo_cnt_reg + 1'b1;
        end else if (!fifo_push && m_accept) begin
            fifo_cnt_next = fifo_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fifo_wr_ptr_reg <= '0;
            fifo_rd_ptr_reg <= '0;
            fifo_cnt_reg    <= '0;
        end else begin
            fifo_cnt_reg <= fifo_cnt_next;
            if (fifo_push) begin
                fifo_wr_ptr_reg <= fifo_wr_ptr_reg + 1'b1;
            end
            if (m_accept) begin
                fifo_rd_ptr_reg <= fifo_rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fifo_push) begin
            fifo_reg[fifo_wr_ptr_reg] <= div_result;
        end
    end

    // Output word.
    assign fifo_head   = fifo_reg[fifo_rd_ptr_reg];
    assign m_valid     = (fifo_cnt_reg != '0);
    assign m_out_red   = fifo_head.red;
    assign m_out_green = fifo_head.green;
    assign m_out_blue  = fifo_head.blue;
    assign m_covered   = fifo_head.covered;

    // Checks.
    `FBAN_ASSERT_ALWAYS(a_credit_covers_queue, resv_reg >= fifo_cnt_reg,
        "credits below queue fill")
    `FBAN_ASSERT_IMPLIES(a_no_queue_overflow, fifo_push, fifo_cnt_reg != FCW'(FD),
        "result queue overflow")
    `FBAN_ASSERT_IMPLIES(a_clear_pipe_empty, clr_active_reg,
        !s1_v_reg && !s2_v_reg && !s3_v_reg, "item in flight during canvas clear")
    `FBAN_ASSERT_IMPLIES(a_uncovered_black, m_valid && !m_covered,
        m_out_red == '0 && m_out_green == '0 && m_out_blue == '0,
        "uncovered result not black")

endmodule
